### rtl/eswl_pkg.sv
// Package with the shared types, codes and defaults of the eHCILL sleep/wake link core.
`default_nettype none
package eswl_pkg;

   // Default depth of the pending byte queue.
   localparam int PENDING_DEPTH_DEFAULT = 32;

   // Reset value of the control code base register (code of SLEEP_IND).
   localparam logic [7:0] CODE_BASE_RESET = 8'd48;

   // Field widths of the request beat.
   localparam int ACTION_W = 2;
   localparam int BYTE_W   = 8;
   localparam int LENGTH_W = 10;

   // Width of the shared subtract unit.
   localparam int ALU_W = 11;

   typedef enum logic [1:0] {
      ACT_RECEIVE = 2'd0,
      ACT_SEND    = 2'd1,
      ACT_ABORT   = 2'd2,
      ACT_UNUSED  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_AWAKE  = 2'd0,
      MODE_ASLEEP = 2'd1,
      MODE_WAKING = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ROUTE_PASS   = 2'd0,
      ROUTE_QUEUE  = 2'd1,
      ROUTE_REJECT = 2'd2
   } route_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_LINK   = 2'd1,
      KIND_PARSER = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_PROTOCOL = 2'd1,
      ERR_NO_ROOM  = 2'd2
   } err_type;

   // Offsets of the four control codes from the base.
   localparam logic [1:0] OFF_SLEEP_IND = 2'd0;
   localparam logic [1:0] OFF_SLEEP_ACK = 2'd1;
   localparam logic [1:0] OFF_WAKE_IND  = 2'd2;
   localparam logic [1:0] OFF_WAKE_ACK  = 2'd3;

endpackage
`default_nettype wire

### rtl/eswl_if.sv
// Handshake interfaces for the request, response and register write channels.
`default_nettype none
interface eswl_req_if;
   logic                          valid;
   logic                          ready;
   logic [eswl_pkg::ACTION_W-1:0] action;
   logic [eswl_pkg::BYTE_W-1:0]   data_byte;
   logic                          parser_idle;
   logic                          frame_start;
   logic [eswl_pkg::LENGTH_W-1:0] frame_length;

   modport source (output valid, action, data_byte, parser_idle, frame_start, frame_length,
                   input ready);
   modport sink (input valid, action, data_byte, parser_idle, frame_start, frame_length,
                 output ready);
endinterface

interface eswl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  out_kind;
   logic [eswl_pkg::BYTE_W-1:0] out_byte;
   logic [1:0]                  error_code;
   logic                        awake_now;
   logic                        last;

   modport source (output valid, out_kind, out_byte, error_code, awake_now, last,
                   input ready);
   modport sink (input valid, out_kind, out_byte, error_code, awake_now, last,
                 output ready);
endinterface

interface eswl_csr_if;
   logic                        valid;
   logic                        ready;
   logic [eswl_pkg::BYTE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/ehcill_sleep_wake_link_core.sv
// Top level of the host-side eHCILL sleep/wake link core with its pending byte queue.
// A request beat is accepted, executed through the shared subtract unit, and its response
// beat is then held in the response register until it is taken.
// A wake flush reads each queued byte from the queue, loads it as a response and waits for it.
// Response stalls hold the core in its wait state; requests wait while an item is in progress.
// Synchronous active-high reset: link awake, queue empty, frames pass through, base 48.
`default_nettype none
module ehcill_sleep_wake_link_core #(
   parameter int PENDING_DEPTH = eswl_pkg::PENDING_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   eswl_req_if.sink   req_chan,
   eswl_rsp_if.source rsp_chan,
   eswl_csr_if.sink   csr_chan
);

   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int AL = eswl_pkg::ALU_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAIT,
      ST_FLUSH_RD,
      ST_FLUSH_OUT
   } state_type;

   state_type                     state_ff;
   logic [7:0]                    base_ff;
   eswl_pkg::mode_type            mode_ff;
   eswl_pkg::route_type           route_ff;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 flush_idx_ff;
   logic [CW-1:0]                 flush_n_ff;

   // Captured request beat.
   eswl_pkg::action_type          act_ff;
   logic [7:0]                    byte_ff;
   logic                          idle_ff;
   logic                          start_ff;
   logic [eswl_pkg::LENGTH_W-1:0] length_ff;

   // Response register.
   logic                          rsp_valid_ff;
   eswl_pkg::kind_type            rsp_kind_ff;
   logic [7:0]                    rsp_byte_ff;
   eswl_pkg::err_type             rsp_err_ff;
   logic                          rsp_awake_ff;
   logic                          rsp_last_ff;

   // Queue memory and its registered read data.
   logic [7:0]                    pending_mem [PENDING_DEPTH];
   logic [7:0]                    rd_data_ff;

   // Decode results of the execute cycle.
   eswl_pkg::kind_type            kind_in;
   logic [7:0]                    obyte_in;
   eswl_pkg::err_type             err_in;
   logic                          awake_in;
   logic                          last_in;
   logic                          emit_in;
   logic                          flush_in;
   logic                          wr_en_in;
   eswl_pkg::mode_type            mode_in;
   eswl_pkg::route_type           route_in;
   logic [CW-1:0]                 count_in;

   // Shared subtract unit and its operands.
   logic [AL-1:0]                 alu_a;
   logic [AL-1:0]                 alu_b;
   logic [AL-1:0]                 alu_diff;
   logic [CW-1:0]                 room;
   logic [eswl_pkg::LENGTH_W-1:0] need;
   logic                          is_ctrl;
   logic                          no_room;
   logic                          flush_last;
   logic                          rsp_take;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_kind   = rsp_kind_ff;
   assign rsp_chan.out_byte   = rsp_byte_ff;
   assign rsp_chan.error_code = rsp_err_ff;
   assign rsp_chan.awake_now  = rsp_awake_ff;
   assign rsp_chan.last       = rsp_last_ff;

   assign rsp_take   = rsp_valid_ff && rsp_chan.ready;
   assign flush_last = ((flush_idx_ff + CW'(1)) == flush_n_ff);

   // Operand selection: received byte against the code base, or queue room against need.
   assign room  = CW'(PENDING_DEPTH) - count_ff;
   assign need  = (length_ff == '0) ? eswl_pkg::LENGTH_W'(1) : length_ff;
   always_comb begin
      if (act_ff == eswl_pkg::ACT_RECEIVE) begin
         alu_a = AL'(byte_ff);
         alu_b = AL'(base_ff);
      end else begin
         alu_a = AL'(room);
         alu_b = AL'(need);
      end
   end
   assign alu_diff = alu_a - alu_b;
   assign is_ctrl  = idle_ff && !alu_diff[AL-1] && (alu_diff[AL-2:2] == '0);
   assign no_room  = alu_diff[AL-1];

   // Decode of one request beat against the current link state.
   always_comb begin
      kind_in  = eswl_pkg::KIND_NONE;
      obyte_in = '0;
      err_in   = eswl_pkg::ERR_NONE;
      awake_in = (mode_ff == eswl_pkg::MODE_AWAKE);
      last_in  = 1'b1;
      emit_in  = 1'b1;
      flush_in = 1'b0;
      wr_en_in = 1'b0;
      mode_in  = mode_ff;
      route_in = route_ff;
      count_in = count_ff;
      unique case (act_ff)
         eswl_pkg::ACT_RECEIVE: begin
            if (!is_ctrl) begin
               kind_in  = eswl_pkg::KIND_PARSER;
               obyte_in = byte_ff;
            end else begin
               unique case (alu_diff[1:0])
                  eswl_pkg::OFF_SLEEP_IND: begin
                     if (mode_ff == eswl_pkg::MODE_WAKING) begin
                        kind_in = eswl_pkg::KIND_ERROR;
                        err_in  = eswl_pkg::ERR_PROTOCOL;
                     end else begin
                        mode_in  = eswl_pkg::MODE_ASLEEP;
                        awake_in = 1'b0;
                        kind_in  = eswl_pkg::KIND_LINK;
                        obyte_in = base_ff + 8'd1;
                     end
                  end
                  eswl_pkg::OFF_SLEEP_ACK: begin
                     kind_in = eswl_pkg::KIND_ERROR;
                     err_in  = eswl_pkg::ERR_PROTOCOL;
                  end
                  eswl_pkg::OFF_WAKE_IND: begin
                     kind_in  = eswl_pkg::KIND_LINK;
                     obyte_in = base_ff + 8'd3;
                     if (count_ff == '0) begin
                        mode_in  = eswl_pkg::MODE_AWAKE;
                        awake_in = 1'b1;
                     end else begin
                        last_in  = 1'b0;
                        flush_in = 1'b1;
                        count_in = '0;
                     end
                  end
                  default: begin
                     // Wake acknowledge from the controller.
                     if (mode_ff == eswl_pkg::MODE_AWAKE) begin
                        kind_in = eswl_pkg::KIND_NONE;
                     end else if (mode_ff != eswl_pkg::MODE_WAKING) begin
                        kind_in = eswl_pkg::KIND_ERROR;
                        err_in  = eswl_pkg::ERR_PROTOCOL;
                     end else if (count_ff == '0) begin
                        mode_in  = eswl_pkg::MODE_AWAKE;
                        awake_in = 1'b1;
                     end else begin
                        emit_in  = 1'b0;
                        flush_in = 1'b1;
                        count_in = '0;
                     end
                  end
               endcase
            end
         end
         eswl_pkg::ACT_SEND: begin
            if (start_ff) begin
               if (mode_ff == eswl_pkg::MODE_AWAKE) begin
                  route_in = eswl_pkg::ROUTE_PASS;
                  kind_in  = eswl_pkg::KIND_LINK;
                  obyte_in = byte_ff;
               end else if (no_room) begin
                  route_in = eswl_pkg::ROUTE_REJECT;
                  kind_in  = eswl_pkg::KIND_ERROR;
                  err_in   = eswl_pkg::ERR_NO_ROOM;
               end else begin
                  route_in = eswl_pkg::ROUTE_QUEUE;
                  wr_en_in = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (mode_ff == eswl_pkg::MODE_ASLEEP) begin
                     mode_in  = eswl_pkg::MODE_WAKING;
                     kind_in  = eswl_pkg::KIND_LINK;
                     obyte_in = base_ff + 8'd2;
                  end
               end
            end else begin
               priority if (route_ff == eswl_pkg::ROUTE_PASS) begin
                  kind_in  = eswl_pkg::KIND_LINK;
                  obyte_in = byte_ff;
               end else if (route_ff == eswl_pkg::ROUTE_QUEUE) begin
                  if (mode_ff == eswl_pkg::MODE_AWAKE) begin
                     kind_in  = eswl_pkg::KIND_LINK;
                     obyte_in = byte_ff;
                  end else if (count_ff < CW'(PENDING_DEPTH)) begin
                     wr_en_in = 1'b1;
                     count_in = count_ff + CW'(1);
                  end else begin
                     kind_in = eswl_pkg::KIND_ERROR;
                     err_in  = eswl_pkg::ERR_NO_ROOM;
                  end
               end else begin
                  kind_in = eswl_pkg::KIND_NONE;
               end
            end
         end
         eswl_pkg::ACT_ABORT: begin
            count_in = '0;
            mode_in  = eswl_pkg::MODE_ASLEEP;
            route_in = eswl_pkg::ROUTE_REJECT;
            awake_in = 1'b0;
         end
         default: begin
            kind_in = eswl_pkg::KIND_NONE;
         end
      endcase
   end

   // Queue memory: written on an execute cycle, read one entry per flush step.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_EXEC) && wr_en_in) begin
         pending_mem[count_ff[AW-1:0]] <= byte_ff;
      end
      if (state_ff == ST_FLUSH_RD) begin
         rd_data_ff <= pending_mem[flush_idx_ff[AW-1:0]];
      end
   end

   // Sequencer with link state and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= eswl_pkg::CODE_BASE_RESET;
         mode_ff      <= eswl_pkg::MODE_AWAKE;
         route_ff     <= eswl_pkg::ROUTE_PASS;
         count_ff     <= '0;
         flush_idx_ff <= '0;
         flush_n_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            base_ff <= csr_chan.data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  act_ff    <= eswl_pkg::action_type'(req_chan.action);
                  byte_ff   <= req_chan.data_byte;
                  idle_ff   <= req_chan.parser_idle;
                  start_ff  <= req_chan.frame_start;
                  length_ff <= req_chan.frame_length;
                  state_ff  <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               mode_ff      <= mode_in;
               route_ff     <= route_in;
               count_ff     <= count_in;
               flush_idx_ff <= '0;
               flush_n_ff   <= count_ff;
               if (emit_in) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= kind_in;
                  rsp_byte_ff  <= obyte_in;
                  rsp_err_ff   <= err_in;
                  rsp_awake_ff <= awake_in;
                  rsp_last_ff  <= last_in;
                  state_ff     <= ST_WAIT;
               end else if (flush_in) begin
                  state_ff <= ST_FLUSH_RD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WAIT: begin
               if (rsp_take) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= rsp_last_ff ? ST_IDLE : ST_FLUSH_RD;
               end
            end
            ST_FLUSH_RD: begin
               state_ff <= ST_FLUSH_OUT;
            end
            ST_FLUSH_OUT: begin
               // The link is awake once the final queued byte goes out.
               if (flush_last) begin
                  mode_ff <= eswl_pkg::MODE_AWAKE;
               end
               flush_idx_ff <= flush_idx_ff + CW'(1);
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= eswl_pkg::KIND_LINK;
               rsp_byte_ff  <= rd_data_ff;
               rsp_err_ff   <= eswl_pkg::ERR_NONE;
               rsp_awake_ff <= flush_last || (mode_ff == eswl_pkg::MODE_AWAKE);
               rsp_last_ff  <= flush_last;
               state_ff     <= ST_WAIT;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### dv/ehcill_sleep_wake_link_core_tb.sv
// Self-checking testbench for the eHCILL sleep/wake link core with a result predictor.
`timescale 1ns / 1ps
module ehcill_sleep_wake_link_core_tb;

   localparam int QUEUE_DEPTH    = eswl_pkg::PENDING_DEPTH_DEFAULT;
   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int PHASE_BEATS    = 112;

   // One result beat as the core should present it.
   typedef struct {
      eswl_pkg::kind_type kind;
      logic [7:0]         value;
      eswl_pkg::err_type  err;
      logic               awake;
      logic               last;
   } link_result_type;

   // Tracks link mode, the pending queue and the frame route, and predicts
   // every result beat caused by an accepted request beat.
   class link_predictor;
      logic [7:0]          code_base;
      eswl_pkg::mode_type  mode;
      eswl_pkg::route_type route;
      logic [7:0]          pending_bytes [QUEUE_DEPTH];
      int unsigned         pending_count;
      link_result_type     expected_beats [$];
      link_result_type     item_beats [$];
      int                  error_count;

      function new();
         code_base     = eswl_pkg::CODE_BASE_RESET;
         mode          = eswl_pkg::MODE_AWAKE;
         route         = eswl_pkg::ROUTE_PASS;
         pending_count = 0;
         error_count   = 0;
      endfunction

      function void set_code_base(logic [7:0] value);
         code_base = value;
      endfunction

      // Awake flag is taken from the mode at the moment the beat is produced.
      function void add_beat(eswl_pkg::kind_type kind, logic [7:0] value,
                             eswl_pkg::err_type err);
         link_result_type r;
         r.kind  = kind;
         r.value = (kind == eswl_pkg::KIND_LINK || kind == eswl_pkg::KIND_PARSER) ?
                   value : 8'd0;
         r.err   = err;
         r.awake = (mode == eswl_pkg::MODE_AWAKE);
         r.last  = 1'b0;
         item_beats.push_back(r);
      endfunction

      // Drain the queue to the link; the mode turns awake before the final byte.
      function void flush_pending();
         int unsigned n;
         n = (pending_count > QUEUE_DEPTH) ? QUEUE_DEPTH : pending_count;
         for (int unsigned i = 0; i < n; i++) begin
            if (i + 1 == n) mode = eswl_pkg::MODE_AWAKE;
            add_beat(eswl_pkg::KIND_LINK, pending_bytes[i], eswl_pkg::ERR_NONE);
         end
         pending_count = 0;
         mode          = eswl_pkg::MODE_AWAKE;
      endfunction

      function void predict_receive(logic [7:0] value, logic idle);
         int offset;
         offset = int'(value) - int'(code_base);
         if (!idle || offset < 0 || offset > 3) begin
            add_beat(eswl_pkg::KIND_PARSER, value, eswl_pkg::ERR_NONE);
         end else if (offset == int'(eswl_pkg::OFF_SLEEP_IND)) begin
            if (mode == eswl_pkg::MODE_WAKING) begin
               add_beat(eswl_pkg::KIND_ERROR, 8'd0, eswl_pkg::ERR_PROTOCOL);
            end else begin
               mode = eswl_pkg::MODE_ASLEEP;
               add_beat(eswl_pkg::KIND_LINK, code_base + eswl_pkg::OFF_SLEEP_ACK,
                        eswl_pkg::ERR_NONE);
            end
         end else if (offset == int'(eswl_pkg::OFF_SLEEP_ACK)) begin
            add_beat(eswl_pkg::KIND_ERROR, 8'd0, eswl_pkg::ERR_PROTOCOL);
         end else if (offset == int'(eswl_pkg::OFF_WAKE_IND)) begin
            if (pending_count == 0) mode = eswl_pkg::MODE_AWAKE;
            add_beat(eswl_pkg::KIND_LINK, code_base + eswl_pkg::OFF_WAKE_ACK,
                     eswl_pkg::ERR_NONE);
            flush_pending();
         end else begin
            if (mode == eswl_pkg::MODE_AWAKE) begin
               add_beat(eswl_pkg::KIND_NONE, 8'd0, eswl_pkg::ERR_NONE);
            end else if (mode != eswl_pkg::MODE_WAKING) begin
               add_beat(eswl_pkg::KIND_ERROR, 8'd0, eswl_pkg::ERR_PROTOCOL);
            end else if (pending_count == 0) begin
               mode = eswl_pkg::MODE_AWAKE;
               add_beat(eswl_pkg::KIND_NONE, 8'd0, eswl_pkg::ERR_NONE);
            end else begin
               flush_pending();
            end
         end
      endfunction

      function void predict_send(logic [7:0] value, logic start, logic [9:0] length);
         int unsigned need;
         int unsigned room;
         if (start) begin
            need = (length == 0) ? 1 : length;
            room = (pending_count < QUEUE_DEPTH) ? QUEUE_DEPTH - pending_count : 0;
            if (mode == eswl_pkg::MODE_AWAKE) begin
               route = eswl_pkg::ROUTE_PASS;
               add_beat(eswl_pkg::KIND_LINK, value, eswl_pkg::ERR_NONE);
            end else if (need > room) begin
               route = eswl_pkg::ROUTE_REJECT;
               add_beat(eswl_pkg::KIND_ERROR, 8'd0, eswl_pkg::ERR_NO_ROOM);
            end else begin
               route = eswl_pkg::ROUTE_QUEUE;
               pending_bytes[pending_count] = value;
               pending_count++;
               if (mode == eswl_pkg::MODE_ASLEEP) begin
                  mode = eswl_pkg::MODE_WAKING;
                  add_beat(eswl_pkg::KIND_LINK, code_base + eswl_pkg::OFF_WAKE_IND,
                           eswl_pkg::ERR_NONE);
               end else begin
                  add_beat(eswl_pkg::KIND_NONE, 8'd0, eswl_pkg::ERR_NONE);
               end
            end
         end else if (route == eswl_pkg::ROUTE_PASS ||
                      (route == eswl_pkg::ROUTE_QUEUE && mode == eswl_pkg::MODE_AWAKE)) begin
            add_beat(eswl_pkg::KIND_LINK, value, eswl_pkg::ERR_NONE);
         end else if (route == eswl_pkg::ROUTE_QUEUE) begin
            // Later bytes of a queued frame join the queue while there is room.
            if (pending_count < QUEUE_DEPTH) begin
               pending_bytes[pending_count] = value;
               pending_count++;
               add_beat(eswl_pkg::KIND_NONE, 8'd0, eswl_pkg::ERR_NONE);
            end else begin
               add_beat(eswl_pkg::KIND_ERROR, 8'd0, eswl_pkg::ERR_NO_ROOM);
            end
         end else begin
            add_beat(eswl_pkg::KIND_NONE, 8'd0, eswl_pkg::ERR_NONE);
         end
      endfunction

      // Called once per accepted request beat.
      function void note_request(eswl_pkg::action_type act, logic [7:0] value, logic idle,
                                 logic start, logic [9:0] length);
         item_beats.delete();
         case (act)
            eswl_pkg::ACT_RECEIVE: predict_receive(value, idle);
            eswl_pkg::ACT_SEND:    predict_send(value, start, length);
            eswl_pkg::ACT_ABORT: begin
               pending_count = 0;
               mode          = eswl_pkg::MODE_ASLEEP;
               route         = eswl_pkg::ROUTE_REJECT;
               add_beat(eswl_pkg::KIND_NONE, 8'd0, eswl_pkg::ERR_NONE);
            end
            default: add_beat(eswl_pkg::KIND_NONE, 8'd0, eswl_pkg::ERR_NONE);
         endcase
         if (item_beats.size() == 0) add_beat(eswl_pkg::KIND_NONE, 8'd0, eswl_pkg::ERR_NONE);
         item_beats[item_beats.size() - 1].last = 1'b1;
         foreach (item_beats[i]) expected_beats.push_back(item_beats[i]);
      endfunction

      // Called once per accepted result beat.
      function void check_response(logic [1:0] kind, logic [7:0] value, logic [1:0] err,
                                   logic awake, logic last);
         link_result_type r;
         if (expected_beats.size() == 0) begin
            $error("result beat with no expectation: out_kind %0d out_byte %0h", kind, value);
            error_count++;
         end else begin
            r = expected_beats.pop_front();
            if (kind !== r.kind) begin
               $error("out_kind: expected %0d, actual %0d", r.kind, kind);
               error_count++;
            end
            if (value !== r.value) begin
               $error("out_byte: expected %0h, actual %0h", r.value, value);
               error_count++;
            end
            if (err !== r.err) begin
               $error("error_code: expected %0d, actual %0d", r.err, err);
               error_count++;
            end
            if (awake !== r.awake) begin
               $error("awake_now: expected %0d, actual %0d", r.awake, awake);
               error_count++;
            end
            if (last !== r.last) begin
               $error("last: expected %0d, actual %0d", r.last, last);
               error_count++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   eswl_req_if req_chan ();
   eswl_rsp_if rsp_chan ();
   eswl_csr_if csr_chan ();

   ehcill_sleep_wake_link_core #(
      .PENDING_DEPTH(QUEUE_DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   link_predictor predictor;
   int            beats_sent = 0;
   int            idle_cycles = 0;
   bit            req_calm = 1'b0;
   bit            rsp_calm = 1'b0;

   // Free-running clock.
   always #(HALF_PERIOD) clock = ~clock;

   // Gap before the next beat; the calm flag gives stretches with no gaps.
   function automatic int draw_gap(ref bit calm);
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      return calm ? 0 : int'($urandom_range(0, 6));
   endfunction

   function automatic logic [7:0] control_code(logic [1:0] offset);
      return predictor.code_base + offset;
   endfunction

   // Drive one request beat and wait for it to be taken.
   task automatic send_beat(eswl_pkg::action_type act, logic [7:0] value, logic idle,
                            logic start, logic [9:0] length);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.action       <= act;
      req_chan.data_byte    <= value;
      req_chan.parser_idle  <= idle;
      req_chan.frame_start  <= start;
      req_chan.frame_length <= length;
      req_chan.valid        <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predictor.note_request(act, value, idle, start, length);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic receive_byte(logic [7:0] value, logic idle);
      send_beat(eswl_pkg::ACT_RECEIVE, value, idle, 1'b0, 10'($urandom));
   endtask

   task automatic frame_byte(logic [7:0] value, logic start, logic [9:0] length);
      send_beat(eswl_pkg::ACT_SEND, value, 1'($urandom), start, length);
   endtask

   // Let the core drain, then write the control code base.
   task automatic write_code_base(logic [7:0] value);
      req_chan.valid <= 1'b0;
      while (predictor.expected_beats.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_chan.data  <= value;
      csr_chan.valid <= 1'b1;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      predictor.set_code_base(value);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Sleep, then a full-length frame that overruns the queue, then a wake flush.
   task automatic fill_and_flush();
      receive_byte(control_code(eswl_pkg::OFF_SLEEP_IND), 1'b1);
      frame_byte(8'($urandom), 1'b1, 10'(QUEUE_DEPTH));
      repeat (QUEUE_DEPTH + 1) frame_byte(8'($urandom), 1'b0, 10'($urandom));
      receive_byte(control_code(eswl_pkg::OFF_WAKE_IND), 1'b1);
   endtask

   // A host frame; sometimes declared oddly, truncated or overrun.
   task automatic random_frame();
      int          count;
      logic [9:0]  length;
      length = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(1, 6));
      count  = (length == 0) ? 1 : int'(length);
      if (count > 8) count = $urandom_range(1, 8);
      if ($urandom_range(0, 7) == 0) count += $urandom_range(1, 3);
      frame_byte(8'($urandom), 1'b1, length);
      for (int i = 1; i < count; i++) frame_byte(8'($urandom), 1'b0, 10'($urandom));
   endtask

   // One random episode of link traffic.
   task automatic random_episode();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      random_frame();
      else if (pick < 45) receive_byte(control_code(eswl_pkg::OFF_SLEEP_IND), 1'b1);
      else if (pick < 57) receive_byte(control_code(eswl_pkg::OFF_WAKE_IND), 1'b1);
      else if (pick < 67) receive_byte(control_code(eswl_pkg::OFF_WAKE_ACK), 1'b1);
      else if (pick < 71) receive_byte(control_code(eswl_pkg::OFF_SLEEP_ACK), 1'b1);
      else if (pick < 80) receive_byte(8'($urandom), 1'($urandom));
      else if (pick < 85) receive_byte(control_code(2'($urandom)), 1'b0);
      else if (pick < 90) send_beat(eswl_pkg::ACT_ABORT, 8'($urandom), 1'($urandom),
                                    1'($urandom), 10'($urandom));
      else if (pick < 93) send_beat(eswl_pkg::ACT_UNUSED, 8'($urandom), 1'($urandom),
                                    1'($urandom), 10'($urandom));
      else if (pick < 96) fill_and_flush();
      else                receive_byte(8'($urandom), 1'b1);
   endtask

   // Result side: stalls drawn per beat.
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Check every result beat taken.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         predictor.check_response(rsp_chan.out_kind, rsp_chan.out_byte, rsp_chan.error_code,
                                  rsp_chan.awake_now, rsp_chan.last);
      end
   end

   // Stop a hung run: count cycles with no beat on any channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Main sequence: reset, directed beats, then random phases per code base.
   initial begin
      logic [7:0] bases [4];
      predictor = new();
      req_chan.valid        = 1'b0;
      req_chan.action       = eswl_pkg::ACT_RECEIVE;
      req_chan.data_byte    = 8'd0;
      req_chan.parser_idle  = 1'b0;
      req_chan.frame_start  = 1'b0;
      req_chan.frame_length = 10'd0;
      csr_chan.valid        = 1'b0;
      csr_chan.data         = 8'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: byte extremes, parser busy, duplicate wake ack and protocol errors.
      receive_byte(8'h00, 1'b1);
      receive_byte(8'hFF, 1'b0);
      receive_byte(control_code(eswl_pkg::OFF_WAKE_ACK), 1'b1);
      receive_byte(control_code(eswl_pkg::OFF_SLEEP_ACK), 1'b1);
      receive_byte(control_code(eswl_pkg::OFF_SLEEP_IND), 1'b0);
      send_beat(eswl_pkg::ACT_UNUSED, 8'hFF, 1'b1, 1'b1, 10'h3FF);
      // Pass-through frame, then wake while awake and go to sleep.
      frame_byte(8'hA5, 1'b1, 10'd3);
      frame_byte(8'h5A, 1'b0, 10'h3FF);
      receive_byte(control_code(eswl_pkg::OFF_WAKE_IND), 1'b1);
      receive_byte(control_code(eswl_pkg::OFF_SLEEP_IND), 1'b1);
      receive_byte(control_code(eswl_pkg::OFF_WAKE_ACK), 1'b1);
      // Frame too long for the queue, then a zero-length frame that wakes the link.
      frame_byte(8'hC3, 1'b1, 10'h3FF);
      frame_byte(8'h3C, 1'b0, 10'd0);
      frame_byte(8'h11, 1'b1, 10'd0);
      receive_byte(control_code(eswl_pkg::OFF_SLEEP_IND), 1'b1);
      frame_byte(8'h22, 1'b0, 10'd0);
      frame_byte(8'h44, 1'b1, 10'd2);
      // Wake ack flushes; the rest of the queued frame then goes straight out.
      receive_byte(control_code(eswl_pkg::OFF_WAKE_ACK), 1'b1);
      frame_byte(8'h33, 1'b0, 10'd0);
      send_beat(eswl_pkg::ACT_ABORT, 8'h00, 1'b0, 1'b0, 10'd0);
      frame_byte(8'h77, 1'b0, 10'd0);
      receive_byte(control_code(eswl_pkg::OFF_WAKE_IND), 1'b1);
      send_beat(eswl_pkg::ACT_ABORT, 8'hFF, 1'b1, 1'b1, 10'h3FF);
      frame_byte(8'h66, 1'b1, 10'd1);
      receive_byte(control_code(eswl_pkg::OFF_WAKE_IND), 1'b1);

      // Random phases, starting each with a full queue and flush.
      bases[0] = 8'd0;
      bases[1] = 8'd252;
      bases[2] = 8'($urandom_range(1, 251));
      bases[3] = eswl_pkg::CODE_BASE_RESET;
      foreach (bases[p]) begin
         write_code_base(bases[p]);
         fill_and_flush();
         while (beats_sent < 25 + (p + 1) * PHASE_BEATS) random_episode();
      end
      req_chan.valid <= 1'b0;

      // Drain and let any stray beat show up.
      while (predictor.expected_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (predictor.error_count == 0 && predictor.expected_beats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### ehcill_sleep_wake_link_core.f
rtl/eswl_pkg.sv
rtl/eswl_if.sv
rtl/ehcill_sleep_wake_link_core.sv
dv/ehcill_sleep_wake_link_core_tb.sv
